@@ hw/rtl/bvt_pkg.sv @@
package bvt_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPERATION_W   = 3;
  localparam int POSITION_W    = 6;
  localparam int IN_WORD_W     = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;

  // Operation codes. Code 7 is unused and does nothing.
  localparam logic [OPERATION_W-1:0] OP_APPEND       = 3'd0;
  localparam logic [OPERATION_W-1:0] OP_READ_FIRST   = 3'd1;
  localparam logic [OPERATION_W-1:0] OP_READ_LAST    = 3'd2;
  localparam logic [OPERATION_W-1:0] OP_READ_AT      = 3'd3;
  localparam logic [OPERATION_W-1:0] OP_REMOVE_FIRST = 3'd4;
  localparam logic [OPERATION_W-1:0] OP_REMOVE_LAST  = 3'd5;
  localparam logic [OPERATION_W-1:0] OP_REMOVE_AT    = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Per-cell control: load the appended word, take the neighbor's word,
  // or drive the held word onto the read tree.
  typedef struct packed {
    logic load;
    logic shift;
    logic sel;
  } cell_ctl_t;

endpackage

@@ hw/rtl/bvt_cell.sv @@
module bvt_cell #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  bvt_pkg::cell_ctl_t     ctl,
  input  logic [WORD_WIDTH-1:0]  new_word,
  input  logic [WORD_WIDTH-1:0]  next_word,
  output logic [WORD_WIDTH-1:0]  word,
  output logic [WORD_WIDTH-1:0]  tap
);

  // Payload register, no reset: contents are only meaningful below the count.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= new_word;
    end else if (ctl.shift) begin
      word <= next_word;
    end
  end

  assign tap = ctl.sel ? word : '0;

endmodule

@@ hw/rtl/bvt_or_tree.sv @@
module bvt_or_tree #(
  parameter int LEAVES     = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [WORD_WIDTH-1:0] leaf [LEAVES],
  output logic [WORD_WIDTH-1:0] root
);

  localparam int NODES = LEAVES - 1;

  // Heap-ordered OR tree with a register at every node; at most one leaf is
  // nonzero, so the root carries the selected word.
  logic [WORD_WIDTH-1:0] node [NODES];

  for (genvar k = 0; k < NODES; k++) begin : g_node
    if (k >= LEAVES / 2 - 1) begin : g_leafs
      always_ff @(posedge clk) begin
        node[k] <= leaf[2*k+1-NODES] | leaf[2*k+2-NODES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[k] <= node[2*k+1] | node[2*k+2];
      end
    end
  end

  assign root = node[0];

endmodule

@@ hw/rtl/bounded_vector_table_core.sv @@
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  operation, position, new_word
// result    out        out_valid / out_stall status, read_word, entry_count,
//                                           is_empty, is_full
//
// Requests other than successful reads register their result in the cycle after
// acceptance. A successful read waits while the selected cell's word passes
// through the registered OR tree that collects it.
// One request is in flight at a time; in_stall is high while a read walks the
// tree or while a result waits under out_stall.
// rst is synchronous and active high; it clears the count and the handshake
// state. Cell contents are not reset.
module bounded_vector_table_core #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bvt_pkg::OPERATION_W-1:0]     operation,
  input  logic [bvt_pkg::POSITION_W-1:0]      position,
  input  logic [bvt_pkg::IN_WORD_W-1:0]       new_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bvt_pkg::STATUS_W-1:0]        status,
  output logic [bvt_pkg::IN_WORD_W-1:0]       read_word,
  output logic [bvt_pkg::ENTRY_COUNT_W-1:0]   entry_count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = IDX_W;
  localparam int LEAVES = 1 << LEVELS;
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int CMP_W  = (CNT_W > bvt_pkg::POSITION_W) ? CNT_W : bvt_pkg::POSITION_W;
  localparam int EXT_W  = (WORD_WIDTH > bvt_pkg::IN_WORD_W) ? WORD_WIDTH : bvt_pkg::IN_WORD_W;
  localparam int CE_W   = (CNT_W > bvt_pkg::ENTRY_COUNT_W) ? CNT_W : bvt_pkg::ENTRY_COUNT_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    target;
  logic [WAIT_W-1:0]   wait_cnt;

  // Decoded request, valid in the cycle it is accepted.
  logic                          accept;
  logic [CMP_W-1:0]              pos_cmp;
  logic [CMP_W-1:0]              cnt_cmp;
  logic [bvt_pkg::STATUS_W-1:0]  req_status;
  logic                          do_append;
  logic                          do_remove;
  logic                          do_shift;
  logic [IDX_W-1:0]              shift_pos;
  logic                          do_read;
  logic [IDX_W-1:0]              read_idx;
  logic [CNT_W-1:0]              count_next;

  logic [EXT_W-1:0]              word_ext;
  logic [WORD_WIDTH-1:0]         word_in;
  logic [WORD_WIDTH-1:0]         tree_root;
  logic [EXT_W-1:0]              root_ext;
  logic [CE_W-1:0]               count_ext;

  bvt_pkg::cell_ctl_t            cell_ctl  [CAPACITY];
  logic [WORD_WIDTH-1:0]         cell_word [CAPACITY];
  logic [WORD_WIDTH-1:0]         cell_tap  [CAPACITY];
  logic [WORD_WIDTH-1:0]         leaf      [LEAVES];

  // A new request waits until the previous result has left the output
  // register and no read is still walking the tree.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign pos_cmp  = CMP_W'(position);
  assign cnt_cmp  = CMP_W'(count);
  assign word_ext = EXT_W'(new_word);
  assign word_in  = word_ext[WORD_WIDTH-1:0];

  // Request decode: status and the effect on the chain.
  always_comb begin
    req_status = bvt_pkg::ST_OK;
    do_append  = 1'b0;
    do_remove  = 1'b0;
    do_shift   = 1'b0;
    shift_pos  = '0;
    do_read    = 1'b0;
    read_idx   = '0;
    unique case (operation) inside
      bvt_pkg::OP_APPEND: begin
        if (count == CNT_W'(CAPACITY)) begin
          req_status = bvt_pkg::ST_FULL;
        end else begin
          do_append = 1'b1;
        end
      end
      bvt_pkg::OP_READ_FIRST, bvt_pkg::OP_READ_LAST,
      bvt_pkg::OP_REMOVE_FIRST, bvt_pkg::OP_REMOVE_LAST: begin
        if (count == '0) begin
          req_status = bvt_pkg::ST_EMPTY;
        end else if (operation == bvt_pkg::OP_READ_FIRST) begin
          do_read = 1'b1;
        end else if (operation == bvt_pkg::OP_READ_LAST) begin
          do_read  = 1'b1;
          read_idx = IDX_W'(count - CNT_W'(1));
        end else if (operation == bvt_pkg::OP_REMOVE_FIRST) begin
          do_remove = 1'b1;
          do_shift  = 1'b1;
        end else begin
          do_remove = 1'b1;
        end
      end
      bvt_pkg::OP_READ_AT, bvt_pkg::OP_REMOVE_AT: begin
        if (count == '0) begin
          req_status = bvt_pkg::ST_EMPTY;
        end else if (pos_cmp >= cnt_cmp) begin
          req_status = bvt_pkg::ST_RANGE;
        end else if (operation == bvt_pkg::OP_READ_AT) begin
          do_read  = 1'b1;
          read_idx = pos_cmp[IDX_W-1:0];
        end else begin
          do_remove = 1'b1;
          do_shift  = 1'b1;
          shift_pos = pos_cmp[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_append) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  // The chain of cells. Each cell decides from its own index whether it
  // takes the appended word, takes its upper neighbor's word on a removal from
  // the front or at or below its index, or drives its word to the read tree.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].load  = accept && do_append && (count == CNT_W'(i));
      cell_ctl[i].shift = accept && do_shift && (shift_pos <= IDX_W'(i));
      cell_ctl[i].sel   = (state == S_READ) && (target == IDX_W'(i));
    end

    if (i < CAPACITY - 1) begin : g_mid
      bvt_cell #(
        .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .new_word  (word_in),
        .next_word (cell_word[i+1]),
        .word      (cell_word[i]),
        .tap       (cell_tap[i])
      );
    end else begin : g_end
      bvt_cell #(
        .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .new_word  (word_in),
        .next_word ({WORD_WIDTH{1'b0}}),
        .word      (cell_word[i]),
        .tap       (cell_tap[i])
      );
    end
  end

  // Leaves past the capacity are tied off so the tree stays a full binary tree.
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign leaf[j] = cell_tap[j];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  bvt_or_tree #(
    .LEAVES     (LEAVES),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (tree_root)
  );

  assign root_ext  = EXT_W'(tree_root);
  assign count_ext = CE_W'(count_next);

  // Control state and the result register. A read holds the chain still and
  // counts down the tree latency before it captures the root. The result
  // register is empty for the whole read, since the read was accepted only
  // once the previous result had left.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      wait_cnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count       <= count_next;
            status      <= req_status;
            read_word   <= '0;
            entry_count <= count_ext[bvt_pkg::ENTRY_COUNT_W-1:0];
            is_empty    <= (count_next == '0);
            is_full     <= (count_next == CNT_W'(CAPACITY));
            out_valid   <= !do_read;
            if (do_read) begin
              state    <= S_READ;
              target   <= read_idx;
              wait_cnt <= WAIT_W'(LEVELS);
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (wait_cnt == '0) begin
            read_word <= root_ext[bvt_pkg::IN_WORD_W-1:0];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            wait_cnt <= wait_cnt - WAIT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
